// File: rtl/core/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared constants and types of the first-fit contiguous allocator: memory
// geometry, field widths, request kinds, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ffca_pkg;

	// memory geometry
	localparam int MEM_WORDS    = 64;
	localparam int ADDR_W       = $clog2(MEM_WORDS);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int HEADER_WORDS = 8;

	// field widths
	localparam int VAR_W   = 4;
	localparam int LINES_W = 7;
	localparam int NEED_W  = 8;

	localparam logic [VAR_W-1:0] VAR_WORDS_RESET = VAR_W'(3);

	// stream word layout
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	localparam int LINES_LSB = 0;
	localparam int RS_LSB    = LINES_LSB + LINES_W;
	localparam int RE_LSB    = RS_LSB + ADDR_W;

	localparam int START_LSB = 0;
	localparam int END_LSB   = START_LSB + ADDR_W;
	localparam int CODE_LSB  = END_LSB + ADDR_W;

	// request kind
	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_POST_OK,
		ST_POST_FAIL
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the request word
		logic scan;      // issue occupancy reads
		logic hit_take;  // latch the found run as write range
		logic wr;        // write one occupancy bit at the write pointer
		logic wr_val;    // value written
		logic post;      // load the result register
		logic post_ok;   // result reports success
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  in_op;      // kind of the offered request
		logic need_bad;   // offered allocation can never fit
		logic range_bad;  // offered release range is reversed
		logic hit;        // free run of the needed length found
		logic miss;       // last word scanned without a fit
		logic wr_last;    // write pointer at the range end
		logic out_free;   // result register can take a word
	} sts_t;

endpackage

// File: rtl/core/ffca_ctrl.sv
// ----------------------------------------------------------------------------
// ffca_ctrl
// Controller of the allocator: clearing pass after reset, request dispatch,
// scan, mark and free sweeps, and result posting.
// ----------------------------------------------------------------------------
module ffca_ctrl
	import ffca_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr     = 1'b1;
				cmd.wr_val = 1'b0;
				if (sts.wr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (sts.in_op == OP_ALLOC) begin
						state_d = sts.need_bad ? ST_POST_FAIL : ST_SCAN;
					end else begin
						state_d = sts.range_bad ? ST_POST_FAIL : ST_FREE;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.hit_take = 1'b1;
					state_d      = ST_MARK;
				end else if (sts.miss) begin
					state_d = ST_POST_FAIL;
				end
			end
			ST_MARK: begin
				cmd.wr     = 1'b1;
				cmd.wr_val = 1'b1;
				if (sts.wr_last) begin
					state_d = ST_POST_OK;
				end
			end
			ST_FREE: begin
				cmd.wr     = 1'b1;
				cmd.wr_val = 1'b0;
				if (sts.wr_last) begin
					state_d = ST_POST_OK;
				end
			end
			ST_POST_OK: begin
				if (sts.out_free) begin
					cmd.post    = 1'b1;
					cmd.post_ok = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_POST_FAIL: begin
				if (sts.out_free) begin
					cmd.post    = 1'b1;
					cmd.post_ok = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// File: rtl/core/ffca_dp.sv
// ----------------------------------------------------------------------------
// ffca_dp
// Datapath of the allocator: occupancy memory, variable-words register,
// scan pipeline with run tracking, write pointer and result register.
// ----------------------------------------------------------------------------
module ffca_dp
	import ffca_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [VAR_W-1:0]     cfg_wdata,
	input  logic                 s_tuser,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic                 m_tuser,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	logic             mem_q [MEM_WORDS];
	logic [VAR_W-1:0] var_words_q;

	logic [LINES_W-1:0] in_lines;
	logic [ADDR_W-1:0]  in_rs;
	logic [ADDR_W-1:0]  in_re;
	logic [NEED_W-1:0]  in_need;

	op_t               op_q;
	logic [NEED_W-1:0] need_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              rd_more;
	logic              rd_vld_s1;
	logic              rd_data_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic [CNT_W-1:0]  run_q;
	logic [ADDR_W-1:0] start_q;
	logic [CNT_W-1:0]  run_next;
	logic [ADDR_W-1:0] hit_start;
	logic [NEED_W-1:0] hit_end;
	logic [ADDR_W-1:0] alloc_start_q;
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] wr_end_q;

	logic              out_vld_q;
	logic              res_ok_q;
	logic [ADDR_W-1:0] res_start_q;
	logic [ADDR_W-1:0] res_end_q;
	logic [ADDR_W-1:0] res_code_q;

	// request fields and word count needed
	assign in_lines = s_tdata[LINES_LSB +: LINES_W];
	assign in_rs    = s_tdata[RS_LSB +: ADDR_W];
	assign in_re    = s_tdata[RE_LSB +: ADDR_W];
	assign in_need  = NEED_W'(HEADER_WORDS) + NEED_W'(var_words_q) + NEED_W'(in_lines);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_words_q <= VAR_WORDS_RESET;
		end else if (cfg_we) begin
			var_words_q <= cfg_wdata;
		end
	end

	// occupancy memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[wr_ptr_q] <= cmd.wr_val;
		end
		rd_data_s1 <= mem_q[rd_cnt_q[ADDR_W-1:0]];
		rd_idx_s1  <= rd_cnt_q[ADDR_W-1:0];
	end

	assign rd_more = (rd_cnt_q < CNT_W'(MEM_WORDS));

	// scan read address and read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan && rd_more;
			if (cmd.load) begin
				rd_cnt_q <= '0;
			end else if (cmd.scan && rd_more) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
		end
	end

	// free run tracking
	assign run_next  = run_q + CNT_W'(1);
	assign hit_start = (run_q == '0) ? rd_idx_s1 : start_q;
	assign hit_end   = NEED_W'(hit_start) + need_q - NEED_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (cmd.load) begin
			run_q <= '0;
		end else if (cmd.scan && rd_vld_s1) begin
			run_q <= rd_data_s1 ? '0 : run_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(s_tuser);
			need_q <= in_need;
		end
		if (cmd.scan && rd_vld_s1 && !rd_data_s1 && run_q == '0) begin
			start_q <= rd_idx_s1;
		end
		if (cmd.hit_take) begin
			alloc_start_q <= hit_start;
		end
	end

	// write range pointer; reset sets up the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			wr_end_q <= ADDR_W'(MEM_WORDS - 1);
		end else if (cmd.load) begin
			wr_ptr_q <= in_rs;
			wr_end_q <= in_re;
		end else if (cmd.hit_take) begin
			wr_ptr_q <= hit_start;
			wr_end_q <= hit_end[ADDR_W-1:0];
		end else if (cmd.wr) begin
			wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.post) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			res_ok_q <= cmd.post_ok;
			if (cmd.post_ok && op_q == OP_ALLOC) begin
				res_start_q <= alloc_start_q;
				res_end_q   <= wr_end_q;
				res_code_q  <= alloc_start_q + ADDR_W'(HEADER_WORDS);
			end else begin
				res_start_q <= '0;
				res_end_q   <= '0;
				res_code_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = res_ok_q;
	always_comb begin
		m_tdata                       = '0;
		m_tdata[START_LSB +: ADDR_W]  = res_start_q;
		m_tdata[END_LSB +: ADDR_W]    = res_end_q;
		m_tdata[CODE_LSB +: ADDR_W]   = res_code_q;
	end

	// status to controller
	always_comb begin
		sts.in_op     = op_t'(s_tuser);
		sts.need_bad  = (in_need == '0) || (in_need > NEED_W'(MEM_WORDS));
		sts.range_bad = (in_rs > in_re);
		sts.hit       = rd_vld_s1 && !rd_data_s1 && (NEED_W'(run_next) == need_q);
		sts.miss      = rd_vld_s1 && (rd_idx_s1 == ADDR_W'(MEM_WORDS - 1))
		                && !(!rd_data_s1 && (NEED_W'(run_next) == need_q));
		sts.wr_last   = (wr_ptr_q == wr_end_q);
		sts.out_free  = !out_vld_q || m_tready;
	end

endmodule

// File: rtl/core/first_fit_contiguous_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator_core
// First-fit allocator over a 64-word occupancy map with range release.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one request word per handshake. s_tuser is the kind
//   (0 allocate, 1 release). An allocation needs 8 header words plus the
//   configured variable words plus code_lines; a release frees an
//   inclusive range, ignored when start is above end.
//   Output stream m_*: one result word per request. m_tuser is ok; on an
//   allocation that fits, m_tdata gives start, end and code start.
//   cfg_we/cfg_wdata write the variable-words register (reset 3) while idle.
// Timing:
//   One request at a time. Allocate: take the word, scan one occupancy bit
//   per cycle through the memory read port (ends early at the first fit),
//   mark the found run word by word, then post once the output register
//   is free. Release: take, free the range, post. Failures skip the sweeps.
//   The single memory write port sets the mark and free cost.
// Reset and stall:
//   After reset a clearing pass frees every word; no request is taken
//   during it. A finished result waits in the output register while
//   the next request is taken; a second result waits until it drains.
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator_core
	import ffca_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [VAR_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 s_tuser,   // op
	input  logic [S_TDATA_W-1:0] s_tdata,   // code_lines, range_start, range_end
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic                 m_tuser,   // ok
	output logic [M_TDATA_W-1:0] m_tdata    // start_addr, end_addr, code_start
);

	cmd_t cmd;
	sts_t sts;

	// controller
	ffca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	ffca_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: bench/tb_first_fit_contiguous_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_first_fit_contiguous_allocator_core
// Self-checking bench for the first-fit allocator core: a local occupancy
// map predicts every result word. Directed requests hit the fit, hole, wrap
// and release corners; random traffic then mixes allocations and releases
// under several variable-word settings with bursty stalls on both streams.
// ----------------------------------------------------------------------------
module tb_first_fit_contiguous_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;
	import ffca_pkg::*;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] end_addr;
		logic [ADDR_W-1:0] code_start;
	} alloc_result_t;

	typedef struct {
		int first;
		int last;
	} run_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [VAR_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic                 s_tuser;   // op
	logic [S_TDATA_W-1:0] s_tdata;   // code_lines, range_start, range_end
	logic                 m_tvalid;
	logic                 m_tready;
	logic                 m_tuser;   // ok
	logic [M_TDATA_W-1:0] m_tdata;   // start_addr, end_addr, code_start

	// shadow occupancy map and variable-words register
	logic [MEM_WORDS-1:0] word_busy;
	logic [VAR_W-1:0]     var_words_shadow;
	alloc_result_t        pending_results[$];
	run_t                 live_runs[$];

	bit calm;
	int errors;
	int mismatches;
	int results_checked;
	int allocs_ok;
	int allocs_failed;
	int releases_done;
	int releases_ignored;

	first_fit_contiguous_allocator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// first-fit search and range free on the shadow map
	function automatic alloc_result_t predict_request(op_t op, int lines, int rs, int re);
		alloc_result_t r;
		int need;
		int run;
		int first;
		int i;
		bit found;
		r = '0;
		run = 0;
		first = 0;
		found = 1'b0;
		if (op == OP_ALLOC) begin
			need = HEADER_WORDS + int'(var_words_shadow) + lines;
			if (need <= MEM_WORDS) begin
				for (i = 0; i < MEM_WORDS && !found; i++) begin
					if (!word_busy[i]) begin
						if (run == 0)
							first = i;
						run++;
						if (run == need)
							found = 1'b1;
					end else begin
						run = 0;
					end
				end
			end
			if (found) begin
				for (i = first; i < first + need; i++)
					word_busy[i] = 1'b1;
				r.ok         = 1'b1;
				r.start_addr = ADDR_W'(first);
				r.end_addr   = ADDR_W'(first + need - 1);
				r.code_start = ADDR_W'(first + HEADER_WORDS);
				live_runs.push_back('{first, first + need - 1});
				allocs_ok++;
			end else begin
				allocs_failed++;
			end
		end else if (rs > re) begin
			releases_ignored++;
		end else begin
			for (i = rs; i <= re; i++)
				word_busy[i] = 1'b0;
			// a full sweep leaves no run worth releasing again
			if (rs == 0 && re == MEM_WORDS - 1)
				live_runs.delete();
			r.ok = 1'b1;
			releases_done++;
		end
		return r;
	endfunction

	// offer one request word, predict it at the accepting edge
	task automatic send_request(op_t op, int lines, int rs, int re);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_TDATA_W'({ADDR_W'(re), ADDR_W'(rs), LINES_W'(lines)});
		do @(negedge clk); while (!s_tready);
		pending_results.push_back(predict_request(op, lines, rs, re));
		@(posedge clk);
	endtask

	task automatic alloc_words(int lines);
		send_request(OP_ALLOC, lines, $urandom_range(0, 63), $urandom_range(0, 63));
	endtask

	task automatic release_words(int rs, int re);
		send_request(OP_RELEASE, $urandom_range(0, 64), rs, re);
	endtask

	// hold the sender until every outstanding result has drained
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_var_words(int value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= VAR_W'(value);
		@(posedge clk);
		var_words_shadow = VAR_W'(value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// fits, failures and hole reuse at the reset setting of three words
	task automatic test_first_fit_basics();
		alloc_words(0);
		alloc_words(64);
		alloc_words(42);
		alloc_words(0);
		release_words(20, 30);
		alloc_words(0);
		release_words(0, 63);
		alloc_words(53);
		release_words(0, 63);
	endtask

	// reversed ranges, single words, already free words, small holes
	task automatic test_release_corners();
		release_words(63, 0);
		release_words(5, 5);
		release_words(63, 63);
		alloc_words(1);
		release_words(0, 0);
		alloc_words(1);
		release_words(0, 63);
		release_words(0, 63);
	endtask

	// smallest and largest variable areas, code start wrapping at the top
	task automatic test_variable_word_extremes();
		write_var_words(0);
		alloc_words(48);
		alloc_words(0);
		alloc_words(0);
		release_words(0, 63);
		write_var_words(15);
		alloc_words(41);
		alloc_words(0);
		release_words(0, 63);
		alloc_words(64);
	endtask

	// mixed traffic, mostly fitting allocations and releases of live runs
	task automatic test_random_traffic(int phases, int per_phase);
		int p;
		int n;
		int pick;
		int k;
		int lines;
		for (p = 0; p < phases; p++) begin
			case (p)
				0: write_var_words(15);
				1: write_var_words(0);
				2: write_var_words(3);
				default: write_var_words($urandom_range(0, 15));
			endcase
			if (p == phases - 1)
				calm = 1'b1;
			for (n = 0; n < per_phase; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					if ($urandom_range(0, 4) == 0)
						lines = $urandom_range(0, 64);
					else
						lines = $urandom_range(0, 12);
					alloc_words(lines);
				end else if (pick < 80 && live_runs.size() != 0) begin
					k = $urandom_range(0, live_runs.size() - 1);
					release_words(live_runs[k].first, live_runs[k].last);
					live_runs.delete(k);
				end else if (pick < 95) begin
					release_words($urandom_range(0, 63), $urandom_range(0, 63));
				end else begin
					release_words(0, 63);
				end
			end
		end
	endtask

	task automatic note_mismatch(string what, alloc_result_t want, alloc_result_t got);
		errors++;
		if (mismatches < 10)
			$display("%0t: %s: want ok=%0d s=%0d e=%0d c=%0d, got ok=%0d s=%0d e=%0d c=%0d",
				$realtime, what, want.ok, want.start_addr, want.end_addr, want.code_start,
				got.ok, got.start_addr, got.end_addr, got.code_start);
		mismatches++;
	endtask

	// result word checker, sampled between edges
	initial begin : result_check
		alloc_result_t want;
		alloc_result_t got;
		forever begin
			@(negedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.ok         = m_tuser;
				got.start_addr = m_tdata[START_LSB +: ADDR_W];
				got.end_addr   = m_tdata[END_LSB +: ADDR_W];
				got.code_start = m_tdata[CODE_LSB +: ADDR_W];
				if (pending_results.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (got !== want)
						note_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	// receiver stalls in bursts until the calm phase
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// test sequence
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tuser   = OP_ALLOC;
		s_tdata   = '0;
		calm      = 1'b0;
		word_busy = '0;
		var_words_shadow = VAR_WORDS_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_first_fit_basics();
		test_release_corners();
		test_variable_word_extremes();
		test_random_traffic(6, 115);

		wait_drained();
		repeat (150) @(posedge clk);
		errors += pending_results.size();

		$display("covered: %0d results, %0d fits, %0d failed allocations",
			results_checked, allocs_ok, allocs_failed);
		$display("covered: %0d ranges freed, %0d reversed ranges ignored",
			releases_done, releases_ignored);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
